// ----- sv/wss_pkg.sv -----
// shared types, command and status codes, register indexes for the signature scanner
`default_nettype none

package wss_pkg;

    localparam int unsigned PAT_BYTES = 32;
    localparam int unsigned PAT_IDX_W = $clog2(PAT_BYTES);
    localparam int unsigned PAT_W     = PAT_BYTES * 8;

    typedef logic [1:0]  t_cmd;
    typedef logic [1:0]  t_status;
    typedef logic [7:0]  t_byte;
    typedef logic [31:0] t_addr;
    typedef logic [31:0] t_flags;
    typedef logic [5:0]  t_len;
    typedef logic [7:0]  t_reg_idx;
    typedef logic [63:0] t_cfg_data;

    localparam t_cmd CMD_DATA   = 2'd0;
    localparam t_cmd CMD_REGION = 2'd1;
    localparam t_cmd CMD_REPORT = 2'd2;

    localparam t_status ST_NONE  = 2'd0;
    localparam t_status ST_FOUND = 2'd1;
    localparam t_status ST_AMBIG = 2'd2;

    localparam t_reg_idx REG_PAT_LO     = 8'd0;
    localparam t_reg_idx REG_PAT_MID_LO = 8'd1;
    localparam t_reg_idx REG_PAT_MID_HI = 8'd2;
    localparam t_reg_idx REG_PAT_HI     = 8'd3;
    localparam t_reg_idx REG_CARE_MASK  = 8'd4;
    localparam t_reg_idx REG_PAT_LEN    = 8'd5;
    localparam t_reg_idx REG_REQ_FLAGS  = 8'd6;
    localparam t_reg_idx REG_FIND_MODE  = 8'd7;

    // per-cell compare setup: the pattern byte lined up with that window slot
    typedef struct packed {
        logic  care;
        t_byte want;
    } t_cell_cfg;

endpackage

`default_nettype wire

// ----- sv/wss_if.sv -----
// handshake channel interfaces: input stream, result stream, register write
`default_nettype none

interface wss_in_if;
    import wss_pkg::*;
    logic   valid;
    logic   ready;
    t_cmd   command;
    t_byte  data_byte;
    t_addr  byte_address;
    t_flags region_flags;

    modport source (output valid, command, data_byte, byte_address, region_flags,
                    input ready);
    modport sink   (input valid, command, data_byte, byte_address, region_flags,
                    output ready);
endinterface

interface wss_out_if;
    import wss_pkg::*;
    logic    valid;
    logic    ready;
    t_status status;
    t_addr   match_address;

    modport source (output valid, status, match_address, input ready);
    modport sink   (input valid, status, match_address, output ready);
endinterface

interface wss_cfg_if;
    import wss_pkg::*;
    logic      valid;
    logic      ready;
    t_reg_idx  index;
    t_cfg_data data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/wildcard_signature_scanner_unit.sv -----
// top level of the wildcard signature scanner
//
//   channel  dir  handshake        payload
//   i_in     in   valid / ready    command, data_byte, byte_address, region_flags
//   o_out    out  valid / ready    status, match_address
//   i_cfg    in   valid / ready    index, data (ready always high)
//
// one input transaction per cycle while i_in.ready is high; the byte shifts
// through a row of MAX_PATTERN window cells that all compare in the same cycle
// a report lands in the output register the cycle after it is taken
// i_in.ready drops in the cycle after each register write while the
// aligned pattern reloads, and also right after reset
// a report also waits while the previous result is held and not yet taken; other
// commands go through regardless of the output side
`default_nettype none

module wildcard_signature_scanner_unit #(
    parameter int unsigned MAX_PATTERN = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wss_in_if.sink     i_in,
    wss_out_if.source  o_out,
    wss_cfg_if.sink    i_cfg
);
    import wss_pkg::*;

    localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);

    logic [PAT_W-1:0]     r_pattern;
    logic [PAT_BYTES-1:0] r_care_mask;
    t_len                 r_len;
    t_flags               r_req_flags;
    logic                 r_find_mode;
    logic                 r_cfg_hold;

    logic [FILL_W-1:0]    r_fill;
    logic [FILL_W-1:0]    n_fill_inc;
    logic                 r_region_en;
    logic [1:0]           r_match_cnt;
    t_addr                r_first_addr;

    logic                 r_out_valid;
    t_status              r_out_status;
    t_addr                r_out_addr;

    t_cell_cfg            w_cell_cfg [MAX_PATTERN];
    t_byte                w_cell_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_hit;

    logic                 w_in_acc;
    logic                 w_cfg_acc;
    logic                 w_shift;
    logic                 w_len_ok;
    logic                 w_match;
    t_addr                w_match_addr;

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_cfg_acc = i_cfg.valid && i_cfg.ready;
    assign w_shift   = w_in_acc && (i_in.command == CMD_DATA) && r_region_en;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_cfg_hold
                         && ((i_in.command != CMD_REPORT) || !r_out_valid || o_out.ready);

    wss_align #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_align (
        .i_clk       (i_clk),
        .i_pattern   (r_pattern),
        .i_care_mask (r_care_mask),
        .i_len       (r_len),
        .o_cell_cfg  (w_cell_cfg)
    );

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        t_byte w_byte_in;
        if (k == 0) begin : g_head
            assign w_byte_in = i_in.data_byte;
        end else begin : g_link
            assign w_byte_in = w_cell_byte[k-1];
        end

        wss_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_byte  (w_byte_in),
            .i_cfg   (w_cell_cfg[k]),
            .o_byte  (w_cell_byte[k]),
            .o_hit   (w_hit[k])
        );
    end

    assign n_fill_inc = (r_fill < FILL_W'(MAX_PATTERN)) ? r_fill + 1'b1 : r_fill;
    assign w_len_ok   = (r_len != '0) && ({1'b0, r_len} <= 7'(MAX_PATTERN));
    assign w_match    = w_shift && w_len_ok && (7'(n_fill_inc) >= {1'b0, r_len})
                        && (&w_hit);
    assign w_match_addr = i_in.byte_address - t_addr'(r_len) + t_addr'(1);

    // registers and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern   <= '0;
            r_care_mask <= '0;
            r_len       <= '0;
            r_req_flags <= '0;
            r_find_mode <= 1'b0;
            r_cfg_hold  <= 1'b1;
            r_fill      <= '0;
            r_region_en <= 1'b0;
            r_match_cnt <= 2'd0;
            r_first_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cfg_hold <= w_cfg_acc;
            if (w_cfg_acc) begin
                unique case (i_cfg.index)
                    REG_PAT_LO:     r_pattern[63:0]    <= i_cfg.data;
                    REG_PAT_MID_LO: r_pattern[127:64]  <= i_cfg.data;
                    REG_PAT_MID_HI: r_pattern[191:128] <= i_cfg.data;
                    REG_PAT_HI:     r_pattern[255:192] <= i_cfg.data;
                    REG_CARE_MASK:  r_care_mask <= i_cfg.data[PAT_BYTES-1:0];
                    REG_PAT_LEN:    r_len       <= i_cfg.data[5:0];
                    REG_REQ_FLAGS:  r_req_flags <= i_cfg.data[31:0];
                    REG_FIND_MODE:  r_find_mode <= i_cfg.data[0];
                    default: ;
                endcase
            end

            if (w_in_acc) begin
                unique case (i_in.command)
                    CMD_DATA: begin
                        if (r_region_en) begin
                            r_fill <= n_fill_inc;
                        end
                        if (w_match) begin
                            if (r_match_cnt == 2'd0) begin
                                r_first_addr <= w_match_addr;
                                r_match_cnt  <= 2'd1;
                            end else if (!r_find_mode) begin
                                r_match_cnt <= 2'd2;
                            end
                        end
                    end
                    CMD_REGION: begin
                        r_fill      <= '0;
                        r_region_en <= (i_in.region_flags & r_req_flags) == r_req_flags;
                    end
                    CMD_REPORT: begin
                        r_fill       <= '0;
                        r_region_en  <= 1'b0;
                        r_match_cnt  <= 2'd0;
                        r_first_addr <= '0;
                    end
                    default: ;
                endcase
            end

            if (w_in_acc && (i_in.command == CMD_REPORT)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in.command == CMD_REPORT)) begin
            r_out_status <= r_match_cnt;
            r_out_addr   <= (r_match_cnt == 2'd1) ? r_first_addr : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out_status;
    assign o_out.match_address = r_out_addr;

endmodule

`default_nettype wire

// ----- sv/wss_align.sv -----
// lines the pattern bytes and care bits up with the window slots, registered
`default_nettype none

module wss_align #(
    parameter int unsigned MAX_PATTERN = 32
) (
    input  wire logic                         i_clk,
    input  wire logic [wss_pkg::PAT_W-1:0]    i_pattern,
    input  wire logic [wss_pkg::PAT_BYTES-1:0] i_care_mask,
    input  wire wss_pkg::t_len                i_len,
    output wss_pkg::t_cell_cfg                o_cell_cfg [MAX_PATTERN]
);
    import wss_pkg::*;

    t_cell_cfg r_cell_cfg [MAX_PATTERN];
    t_cell_cfg n_cell_cfg [MAX_PATTERN];

    // slot k holds the byte k steps back, so it faces pattern byte len-1-k
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_slot
        logic [6:0] w_pos;
        logic       w_in_len;

        assign w_in_len = 7'(k) < {1'b0, i_len};
        assign w_pos    = {1'b0, i_len} - 7'd1 - 7'(k);

        always_comb begin
            n_cell_cfg[k].care = w_in_len && (w_pos < 7'(PAT_BYTES))
                                 && i_care_mask[w_pos[PAT_IDX_W-1:0]];
            n_cell_cfg[k].want = i_pattern[8*w_pos[PAT_IDX_W-1:0] +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell_cfg <= n_cell_cfg;
    end

    assign o_cell_cfg = r_cell_cfg;

endmodule

`default_nettype wire

// ----- sv/wss_cell.sv -----
// one window slot: holds a byte, passes it on, compares the incoming byte
`default_nettype none

module wss_cell (
    input  wire logic               i_clk,
    input  wire logic               i_shift,
    input  wire wss_pkg::t_byte     i_byte,
    input  wire wss_pkg::t_cell_cfg i_cfg,
    output wss_pkg::t_byte          o_byte,
    output logic                    o_hit
);
    import wss_pkg::*;

    t_byte r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // hit on the byte that lands here this cycle
    assign o_hit  = !i_cfg.care || (i_byte == i_cfg.want);
    assign o_byte = r_byte;

endmodule

`default_nettype wire

// ----- sv/wss_checker.sv -----
// port-level checks on the signature scanner, bound to the top level
`default_nettype none

module wss_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire wss_pkg::t_cmd    i_in_command,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire wss_pkg::t_status i_out_status,
    input wire wss_pkg::t_addr   i_out_match_address,
    input wire logic             i_cfg_valid,
    input wire logic             i_cfg_ready
);
    import wss_pkg::*;

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
                                        && $stable(i_out_match_address))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status == ST_NONE) || (i_out_status == ST_FOUND)
                        || (i_out_status == ST_AMBIG))
        else $error("bad status code");

    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_FOUND) |-> i_out_match_address == '0)
        else $error("address set without a match");

    // a result only follows a report transaction
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready
                                     && (i_in_command == CMD_REPORT)))
        else $error("result without a report");

    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_ready |=> !i_in_ready)
        else $error("input taken while pattern reloads");

endmodule

bind wildcard_signature_scanner_unit wss_checker u_wss_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_in_command        (i_in.command),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_status        (o_out.status),
    .i_out_match_address (o_out.match_address),
    .i_cfg_valid         (i_cfg.valid),
    .i_cfg_ready         (i_cfg.ready)
);

`default_nettype wire
